// File: rtl/kwpq_pkg.sv
package kwpq_pkg;

    // Request codes as they arrive on the input channel.
    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_DUMP   = 2'd3
    } t_req;

    // Status codes of a result item.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] key;
        logic [31:0] weight;
        logic [31:0] payload;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [31:0] entry_key;
        logic [31:0] entry_weight;
        logic [31:0] entry_payload;
        logic        last;
    } t_out_item;

    // A classified request as it travels from the front to the engine.
    typedef struct packed {
        t_req        req;
        logic [31:0] key;
        logic [31:0] weight;
        logic [31:0] payload;
    } t_cmd;

endpackage

// File: rtl/kwpq_ram.sv
module kwpq_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/kwpq_front.sv
module kwpq_front
    import kwpq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    output logic     o_in_stall,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;
    t_cmd       cmd;

    // Classify the request code into the command enum.
    always_comb begin
        cmd.key     = i_in_item.key;
        cmd.weight  = i_in_item.weight;
        cmd.payload = i_in_item.payload;
        cmd.req     = t_req'(i_in_item.req_type);
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign pop         = i_cmd_pop && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // Two-entry queue between the front and the engine.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// File: rtl/kwpq_engine.sv
module kwpq_engine
    import kwpq_pkg::*;
#(
    parameter int CAPACITY      = 32,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int EW = 64 + PAYLOAD_WIDTH;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE, S_FRD, S_FCMP, S_DROP_RD, S_DROP_WR, S_PRD, S_PCMP,
        S_SH, S_SHWR, S_DRD, S_DOUT, S_OUT
    } t_state;

    t_state    r_state, n_state;
    t_cmd      r_cmd, n_cmd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_pos, n_pos;
    t_out_item r_res, n_res;
    logic      r_ov;
    t_out_item r_out;
    logic      out_free;

    logic          ram_we;
    logic [CW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic          ram_re;
    logic [CW-1:0] ram_raddr;
    logic [EW-1:0] rd_data;

    logic [31:0]              rd_key;
    logic [31:0]              rd_weight;
    logic [PAYLOAD_WIDTH-1:0] rd_pay;
    logic [63:0]              pay_in_ext;
    logic [63:0]              pay_out_ext;
    logic [EW-1:0]            new_entry;

    kwpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr[AW-1:0]),
        .o_rdata (rd_data)
    );

    // Entry word layout: key, weight, payload.
    assign rd_key      = rd_data[EW-1 -: 32];
    assign rd_weight   = rd_data[EW-33 -: 32];
    assign rd_pay      = rd_data[PAYLOAD_WIDTH-1:0];
    assign pay_in_ext  = {32'd0, r_cmd.payload};
    assign pay_out_ext = 64'(rd_pay);
    assign new_entry   = {r_cmd.key, r_cmd.weight, pay_in_ext[PAYLOAD_WIDTH-1:0]};

    assign out_free    = !r_ov || !i_out_stall;
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    // Sequencer for search, shift and dump walks over the entry memory.
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_res     = r_res;
        o_cmd_pop = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = rd_data;
        ram_re    = 1'b0;
        ram_raddr = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_idx     = '0;
                    n_res     = '0;
                    n_res.last = 1'b1;
                    if (i_cmd.req == REQ_DUMP) begin
                        if (r_cnt == '0) begin
                            n_res.status = ST_EMPTY;
                            n_state      = S_OUT;
                        end else begin
                            n_idx   = r_cnt - 1'b1;
                            n_state = S_DRD;
                        end
                    end else begin
                        n_state = S_FRD;
                    end
                end
            end
            S_FRD: begin
                if (r_idx == r_cnt) begin
                    // The key is absent.
                    unique case (r_cmd.req)
                        REQ_INSERT: begin
                            if (r_cnt == CAP) begin
                                n_res.status = ST_FULL;
                                n_state      = S_OUT;
                            end else begin
                                n_idx   = '0;
                                n_state = S_PRD;
                            end
                        end
                        REQ_REMOVE: begin
                            n_res.status = ST_NOT_FOUND;
                            n_state      = S_OUT;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_FCMP;
                end
            end
            S_FCMP: begin
                if (rd_key == r_cmd.key) begin
                    if (r_cmd.req == REQ_LOOKUP) begin
                        n_res.found = 1'b1;
                        n_state     = S_OUT;
                    end else begin
                        n_state = S_DROP_RD;
                    end
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_FRD;
                end
            end
            S_DROP_RD: begin
                if (r_idx + 1'b1 >= r_cnt) begin
                    n_cnt = r_cnt - 1'b1;
                    if (r_cmd.req == REQ_INSERT) begin
                        n_idx   = '0;
                        n_state = S_PRD;
                    end else begin
                        n_state = S_OUT;
                    end
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx + 1'b1;
                    n_state   = S_DROP_WR;
                end
            end
            S_DROP_WR: begin
                ram_we  = 1'b1;
                n_idx   = r_idx + 1'b1;
                n_state = S_DROP_RD;
            end
            S_PRD: begin
                if (r_idx == r_cnt) begin
                    n_pos   = r_cnt;
                    n_idx   = r_cnt;
                    n_state = S_SH;
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_PCMP;
                end
            end
            S_PCMP: begin
                // Equal weights stay in front of the new entry.
                if (rd_weight >= r_cmd.weight) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_PRD;
                end else begin
                    n_pos   = r_idx;
                    n_idx   = r_cnt;
                    n_state = S_SH;
                end
            end
            S_SH: begin
                if (r_idx == r_pos) begin
                    ram_we    = 1'b1;
                    ram_wdata = new_entry;
                    n_cnt     = r_cnt + 1'b1;
                    n_state   = S_OUT;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx - 1'b1;
                    n_state   = S_SHWR;
                end
            end
            S_SHWR: begin
                ram_we  = 1'b1;
                n_idx   = r_idx - 1'b1;
                n_state = S_SH;
            end
            S_DRD: begin
                ram_re  = 1'b1;
                n_state = S_DOUT;
            end
            S_DOUT: begin
                n_res.status        = ST_OK;
                n_res.found         = 1'b0;
                n_res.entry_key     = rd_key;
                n_res.entry_weight  = rd_weight;
                n_res.entry_payload = pay_out_ext[31:0];
                n_res.last          = (r_idx == '0);
                n_state             = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    if (r_res.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = S_DRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, working registers and the output register.
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_idx <= n_idx;
        r_pos <= n_pos;
        r_res <= n_res;
        if (r_state == S_OUT && out_free) begin
            r_out <= r_res;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (r_state == S_OUT && out_free) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP) else $error("entry count above capacity");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == $past(r_cnt)) || (r_cnt == $past(r_cnt) + 1'b1)
        || (r_cnt == $past(r_cnt) - 1'b1)) else $error("entry count jumped");
    a_grow_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SH && n_cnt != r_cnt) |-> ram_we)
        else $error("entry counted without a write");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == S_IDLE)) else $error("command taken while busy");
`endif

endmodule

// File: rtl/keyed_weight_priority_queue.sv
// Channel  Direction  Handshake                Item
// in       input      i_in_valid / o_in_stall   t_in_item (req_type, key, weight, payload)
// out      output     o_out_valid / i_out_stall t_out_item (status .. last)
//
// A request walks the entries one at a time: key search, drop shift, sorted position
// search and insert shift each read one entry of the entry memory and use it in
// the next cycle. A dump gives one result per entry, last entry first, and reads each
// only after the output register took the previous one. Requests are taken one at a time.
// Reset is synchronous and active low and clears the entry count; no clearing pass.
// A two-item input queue and one output register let either side stall alone.
module keyed_weight_priority_queue
    import kwpq_pkg::*;
#(
    parameter int CAPACITY      = 32,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    // Front: accept and classify requests.
    kwpq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Back: carry requests out against the sorted store.
    kwpq_engine #(
        .CAPACITY      (CAPACITY),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule
